// File: rtl/cluster_score_outer_product_sum_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cluster score outer-product sum block
// Both macros sample on the rising edge of clk and are switched off in reset.
// ---------------------------------------------------------------------------
`ifndef CLUSTER_SCORE_OUTER_PRODUCT_SUM_MACROS_SVH
`define CLUSTER_SCORE_OUTER_PRODUCT_SUM_MACROS_SVH

// Same-cycle implication.
`define CSOPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSOPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csops_pkg.sv
// ---------------------------------------------------------------------------
// csops_pkg
// Word types and fixed widths of the cluster score outer-product sum block.
// ---------------------------------------------------------------------------
`default_nettype none

package csops_pkg;

  localparam int unsigned X_W     = 16;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned K_W     = 4;
  localparam logic [K_W-1:0] K_RESET = 4'd8;

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic signed [X_W-1:0] residual;
    logic                  end_of_row;
    logic                  end_of_cluster;
    logic                  end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]        row_index;
    logic [CNT_W-1:0]        col_index;
    logic signed [SUM_W-1:0] entry_value;
    logic                    last_entry;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/csops_mul.sv
// ---------------------------------------------------------------------------
// csops_mul
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
`default_nettype none

module csops_mul
  import csops_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [SCORE_W-1:0] op_a,
  input  wire logic signed [SCORE_W-1:0] op_b,
  output logic signed [SUM_W-1:0]        prod
);

  logic signed [SUM_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: rtl/csops_mat.sv
// ---------------------------------------------------------------------------
// csops_mat
// Sum matrix storage: one write and one registered read port per cycle.
// Per-entry valid bits make unwritten entries read as zero, so reset and
// the end-of-data clear need no pass over the memory.
// ---------------------------------------------------------------------------
`default_nettype none

module csops_mat
  import csops_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic signed [SUM_W-1:0] wr_data,
  input  wire logic [AW-1:0]           rd_addr,
  input  wire logic                    clr,
  output logic signed [SUM_W-1:0]      rd_data
);

  localparam int unsigned DEPTH = 1 << AW;

  logic signed [SUM_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]        vld_r;
  logic signed [SUM_W-1:0] rd_data_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// File: rtl/cluster_score_outer_product_sum.sv
// ---------------------------------------------------------------------------
// cluster_score_outer_product_sum
// Accumulates per-column scores x*e over a cluster, folds the outer product
// of the score vector into a K-by-K sum matrix at each cluster end and at
// end of data, and emits the matrix row-major at end of data.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Word
//   in_      input      in_valid / in_stall   in_word_t (one regressor element)
//   out_     output     out_valid / out_stall out_word_t (one matrix entry)
//   cfg_     input      cfg_we                cfg_wdata = num_regressors
//
// An ordinary element first feeds the shared multiplier and then adds the
// product into its score. A cluster end or end of data also folds the
// outer product, each entry reading the matrix and writing back through
// the same multiplier and memory port. End of data then emits the K*K
// entries one by one, each held until the output is not stalled.
// Reset is synchronous; the matrix is cleared through its valid bits, so
// there is no clearing pass and the block is ready right after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cluster_score_outer_product_sum_macros.svh"

module cluster_score_outer_product_sum
  import csops_pkg::*;
#(
  parameter int unsigned MAX_REGRESSORS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_word_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_word_t            out_data,
  input  wire logic            cfg_we,
  input  wire logic [K_W-1:0]  cfg_wdata
);

  // Index width for one matrix dimension; the matrix address is {row, col}.
  localparam int unsigned IW = (MAX_REGRESSORS > 1) ? $clog2(MAX_REGRESSORS) : 1;
  localparam int unsigned AW = 2 * IW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_OP_LOAD,
    ST_OP_MUL,
    ST_OP_WB,
    ST_EM_RD,
    ST_EM_LOAD,
    ST_EM_WAIT
  } state_t;

  state_t                    state_r;
  logic [K_W-1:0]            num_r;
  logic [CNT_W-1:0]          col_r;
  logic [CNT_W-1:0]          acc_col_r;
  logic                      fold_r;
  logic                      eod_r;
  logic [IW-1:0]             i_r;
  logic [IW-1:0]             j_r;
  logic signed [SCORE_W-1:0] si_r;
  logic signed [SCORE_W-1:0] score_r [MAX_REGRESSORS];
  logic                      out_valid_r;
  out_word_t                 out_data_r;

  logic [K_W-1:0]            k_eff;
  logic                      accept;
  logic                      i_last;
  logic                      j_last;
  logic [IW-1:0]             rd_idx;
  logic signed [SCORE_W-1:0] score_rd;
  logic signed [SCORE_W-1:0] mul_a;
  logic signed [SCORE_W-1:0] mul_b;
  logic signed [SUM_W-1:0]   prod;
  logic signed [SCORE_W:0]   score_sum;
  logic signed [SCORE_W-1:0] score_sat;
  logic signed [SUM_W:0]     entry_sum;
  logic signed [SUM_W-1:0]   entry_sat;
  logic signed [SUM_W-1:0]   mat_rdata;
  logic                      mat_we;
  logic                      mat_clr;

  // A register value of zero acts as one column, and values above the
  // supported maximum are clamped to it.
  always_comb begin
    if (num_r == '0) begin
      k_eff = K_W'(1);
    end else if (num_r > K_W'(MAX_REGRESSORS)) begin
      k_eff = K_W'(MAX_REGRESSORS);
    end else begin
      k_eff = num_r;
    end
  end

  assign accept = in_valid && !in_stall;
  assign i_last = (K_W'(i_r) == k_eff - K_W'(1));
  assign j_last = (K_W'(j_r) == k_eff - K_W'(1));

  // The score vector has a single read port, steered by the sequencer.
  always_comb begin
    case (state_r)
      ST_ACC:     rd_idx = acc_col_r[IW-1:0];
      ST_OP_LOAD: rd_idx = i_r;
      default:    rd_idx = j_r;
    endcase
  end
  assign score_rd = score_r[rd_idx];

  // In idle the multiplier takes x*e straight from the input word; in the
  // outer-product loop it forms score[i]*score[j].
  always_comb begin
    if (state_r == ST_IDLE) begin
      mul_a = SCORE_W'(in_data.x_value);
      mul_b = SCORE_W'(in_data.residual);
    end else begin
      mul_a = si_r;
      mul_b = score_rd;
    end
  end

  csops_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Saturating score update. The element product always fits 32 bits.
  always_comb begin
    score_sum = {score_rd[SCORE_W-1], score_rd} + {prod[SCORE_W-1], prod[SCORE_W-1:0]};
    if (score_sum[SCORE_W] != score_sum[SCORE_W-1]) begin
      score_sat = score_sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                     : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      score_sat = score_sum[SCORE_W-1:0];
    end
  end

  // Saturating matrix update with the product of two scores.
  always_comb begin
    entry_sum = {mat_rdata[SUM_W-1], mat_rdata} + {prod[SUM_W-1], prod};
    if (entry_sum[SUM_W] != entry_sum[SUM_W-1]) begin
      entry_sat = entry_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      entry_sat = entry_sum[SUM_W-1:0];
    end
  end

  assign mat_we  = (state_r == ST_OP_WB);
  assign mat_clr = (state_r == ST_EM_WAIT) && !out_stall && i_last && j_last;

  csops_mat #(
    .AW (AW)
  ) u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mat_we),
    .wr_addr ({i_r, j_r}),
    .wr_data (entry_sat),
    .rd_addr ({i_r, j_r}),
    .clr     (mat_clr),
    .rd_data (mat_rdata)
  );

  // Sequencer: state, scores, counters and the output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_r       <= K_RESET;
      col_r       <= '0;
      acc_col_r   <= '0;
      fold_r      <= 1'b0;
      eod_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < MAX_REGRESSORS; n++) begin
        score_r[n] <= '0;
      end
    end else begin
      if (cfg_we) begin
        num_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            acc_col_r <= col_r;
            fold_r    <= in_data.end_of_cluster || in_data.end_of_data;
            eod_r     <= in_data.end_of_data;
            if (in_data.end_of_row || in_data.end_of_cluster || in_data.end_of_data) begin
              col_r <= '0;
            end else begin
              col_r <= col_r + CNT_W'(1);
            end
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          // Columns at or beyond K are dropped.
          if (K_W'(acc_col_r) < k_eff) begin
            score_r[acc_col_r[IW-1:0]] <= score_sat;
          end
          i_r <= '0;
          j_r <= '0;
          state_r <= fold_r ? ST_OP_LOAD : ST_IDLE;
        end
        ST_OP_LOAD: begin
          si_r    <= score_rd;
          state_r <= ST_OP_MUL;
        end
        ST_OP_MUL: begin
          state_r <= ST_OP_WB;
        end
        ST_OP_WB: begin
          if (!j_last) begin
            j_r     <= j_r + IW'(1);
            state_r <= ST_OP_MUL;
          end else if (!i_last) begin
            i_r     <= i_r + IW'(1);
            j_r     <= '0;
            state_r <= ST_OP_LOAD;
          end else begin
            for (int n = 0; n < MAX_REGRESSORS; n++) begin
              score_r[n] <= '0;
            end
            i_r     <= '0;
            j_r     <= '0;
            state_r <= eod_r ? ST_EM_RD : ST_IDLE;
          end
        end
        ST_EM_RD: begin
          state_r <= ST_EM_LOAD;
        end
        ST_EM_LOAD: begin
          out_data_r.row_index   <= CNT_W'(i_r);
          out_data_r.col_index   <= CNT_W'(j_r);
          out_data_r.entry_value <= mat_rdata;
          out_data_r.last_entry  <= i_last && j_last;
          out_valid_r            <= 1'b1;
          state_r                <= ST_EM_WAIT;
        end
        ST_EM_WAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (!j_last) begin
              j_r     <= j_r + IW'(1);
              state_r <= ST_EM_RD;
            end else if (!i_last) begin
              i_r     <= i_r + IW'(1);
              j_r     <= '0;
              state_r <= ST_EM_RD;
            end else begin
              // The matrix clears through its valid bits in this cycle.
              i_r     <= '0;
              j_r     <= '0;
              col_r   <= '0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // No new element is taken while a matrix entry is on offer.
  `CSOPS_ASSERT_NOW(a_no_accept_during_emit, out_valid, in_stall, "input taken during emission")

  // An accepted element always occupies the block in the next cycle.
  `CSOPS_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "block ready right after accept")

  // An element without a cluster or data end leaves the block ready again after its score update.
  `CSOPS_ASSERT_NEXT(a_plain_two_cycles,
    accept && !in_data.end_of_cluster && !in_data.end_of_data,
    ##1 !in_stall, "plain element took more than two cycles")

  // Once the last entry is taken the emission is over.
  `CSOPS_ASSERT_NEXT(a_last_ends_emit,
    out_valid && !out_stall && out_data.last_entry,
    !out_valid && !in_stall, "emission continued past last entry")

endmodule

`default_nettype wire
